FILE: rtl/ica_pkg.sv
// shared types, codes and widths for the interval colour allocator
package ica_pkg;

  localparam int MAX_COLORS_DEF = 64;
  localparam int MAX_VALUES_DEF = 1024;

  localparam int REQ_W    = 2;
  localparam int ID_W     = 10;
  localparam int COLOR_W  = 6;
  localparam int STATUS_W = 2;
  localparam int NUMC_W   = 7;
  localparam int EPOCH_W  = 8;
  localparam int GROUP_W  = 8;

  localparam logic [NUMC_W-1:0] NUMC_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_BLOCK   = 2'd0,
    REQ_LIVE_IN = 2'd1,
    REQ_DEF     = 2'd2,
    REQ_USE     = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_COLOR     = 2'd1,
    ST_USE_NOT_LIVE = 2'd2,
    ST_DEF_LIVE     = 2'd3
  } status_t;

  typedef struct packed {
    logic               hit;
    logic [COLOR_W-1:0] color;
  } scan_res_t;

endpackage

FILE: rtl/interval_color_allocator.sv
// top level: greedy interval colour allocator driven by border events
//
// Events enter on the in_valid/in_ready channel (req_type, value_id,
// def_is_live_in); one result beat (color, status) leaves on out_valid/
// out_ready for every event, in order. num_colors is written through
// cfg_we/cfg_wdata and should only change while the block is idle.
// One event is worked on at a time and in_ready is low meanwhile.
// A block start goes straight from acceptance to the finish stage. A live-in or
// use passes through reduce, read of the per-value memories, then finish. A def
// that searches adds a scan of the busy mask before finish, one 8-bit group
// per cycle; a skipped def or a def of a live value goes to finish unsearched.
// A value_id at or above MAX_VALUES is reduced by repeated subtraction first.
// A finished result sits in the output register; the next event is still
// accepted, and its finish stage waits until the output register is free.
// After reset, and after every 255th block start, a clearing pass over all
// MAX_VALUES entries resets the live marks; in_ready stays low during it.
// Live marks are epoch tags, so a block start otherwise needs no sweep.
module interval_color_allocator #(
  parameter int MAX_COLORS = ica_pkg::MAX_COLORS_DEF,
  parameter int MAX_VALUES = ica_pkg::MAX_VALUES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ica_pkg::REQ_W-1:0]    req_type,
  input  logic [ica_pkg::ID_W-1:0]     value_id,
  input  logic                         def_is_live_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ica_pkg::COLOR_W-1:0]  color,
  output logic [ica_pkg::STATUS_W-1:0] status,
  input  logic                         cfg_we,
  input  logic [ica_pkg::NUMC_W-1:0]   cfg_wdata
);
  import ica_pkg::*;

  localparam int NG    = (MAX_COLORS + GROUP_W - 1) / GROUP_W;
  localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
  localparam int IDX_W = $clog2(MAX_VALUES);
  localparam int MV_W  = $clog2(MAX_VALUES + 1);
  localparam int CMP_W = (ID_W > MV_W) ? ID_W : MV_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RED,
    S_LOOK,
    S_SCAN,
    S_FIN
  } state_t;

  state_t              state;
  req_t                req_q;
  logic                dli_q;
  logic [CMP_W-1:0]    v_reg;
  logic [IDX_W-1:0]    clr_cnt;
  logic [GW-1:0]       grp;
  logic [MAX_COLORS-1:0] busy;
  logic [EPOCH_W-1:0]  epoch;
  logic [NUMC_W-1:0]   num_colors;
  logic [COLOR_W-1:0]  res_color;
  status_t             res_status;

  logic [EPOCH_W-1:0]  tag_mem [MAX_VALUES];
  logic [COLOR_W-1:0]  col_mem [MAX_VALUES];
  logic [EPOCH_W-1:0]  tag_rd;
  logic [COLOR_W-1:0]  col_rd;

  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                load_out;
  logic                commit_ok;
  logic                tag_we;
  logic [EPOCH_W-1:0]  tag_wdata;
  logic                col_we;
  logic [MAX_COLORS-1:0] color_bit;
  logic                live;
  scan_res_t           scan;

  ica_free_scan #(
    .MAX_COLORS (MAX_COLORS)
  ) u_scan (
    .busy       (busy),
    .num_colors (num_colors),
    .grp        (grp),
    .res        (scan)
  );

  assign in_ready  = (state == S_IDLE);
  assign rd_addr   = v_reg[IDX_W-1:0];
  assign live      = (tag_rd == epoch);
  assign load_out  = (state == S_FIN) && (!out_valid || out_ready);
  assign commit_ok = load_out && (res_status == ST_OK);
  assign color_bit = MAX_COLORS'(1) << res_color;

  assign tag_we = (state == S_CLEAR) ||
                  (commit_ok && ((req_q == REQ_LIVE_IN) || (req_q == REQ_USE) ||
                                 ((req_q == REQ_DEF) && !dli_q)));
  assign tag_wdata = ((state == S_CLEAR) || (req_q == REQ_USE)) ? '0 : epoch;
  assign wr_addr   = (state == S_CLEAR) ? clr_cnt : rd_addr;
  assign col_we    = commit_ok && (req_q == REQ_DEF) && !dli_q;

  // per-value live tags and colours
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[wr_addr] <= tag_wdata;
    end
    if (col_we) begin
      col_mem[wr_addr] <= res_color;
    end
    tag_rd <= tag_mem[rd_addr];
    col_rd <= col_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      out_valid  <= 1'b0;
      busy       <= '0;
      epoch      <= EPOCH_W'(1);
      num_colors <= NUMC_RESET;
      clr_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        num_colors <= cfg_wdata;
      end
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(MAX_VALUES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_q <= req_t'(req_type);
            dli_q <= def_is_live_in;
            v_reg <= CMP_W'(value_id);
            if (req_t'(req_type) == REQ_BLOCK) begin
              res_color  <= '0;
              res_status <= ST_OK;
              state      <= S_FIN;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (v_reg >= CMP_W'(MAX_VALUES)) begin
            v_reg <= v_reg - CMP_W'(MAX_VALUES);
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          grp <= '0;
          case (req_q)
            REQ_LIVE_IN: begin
              res_color  <= col_rd;
              res_status <= ST_OK;
              state      <= S_FIN;
            end
            REQ_DEF: begin
              res_color <= '0;
              if (!dli_q && live) begin
                res_status <= ST_DEF_LIVE;
                state      <= S_FIN;
              end else if (!dli_q) begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end else begin
                res_status <= ST_OK;
                state      <= S_FIN;
              end
            end
            REQ_USE: begin
              state <= S_FIN;
              if (live) begin
                res_color  <= col_rd;
                res_status <= ST_OK;
              end else begin
                res_color  <= '0;
                res_status <= ST_USE_NOT_LIVE;
              end
            end
            default: begin
              res_color  <= '0;
              res_status <= ST_OK;
              state      <= S_FIN;
            end
          endcase
        end
        S_SCAN: begin
          if (scan.hit) begin
            res_color  <= scan.color;
            res_status <= ST_OK;
            state      <= S_FIN;
          end else if (grp == GW'(NG - 1)) begin
            res_color  <= '0;
            res_status <= ST_NO_COLOR;
            state      <= S_FIN;
          end else begin
            grp <= grp + 1'b1;
          end
        end
        S_FIN: begin
          if (load_out) begin
            out_valid <= 1'b1;
            color     <= res_color;
            status    <= res_status;
            if (commit_ok && (req_q == REQ_BLOCK) && (epoch == '1)) begin
              state <= S_CLEAR;
            end else begin
              state <= S_IDLE;
            end
            if (commit_ok) begin
              case (req_q)
                REQ_LIVE_IN: busy <= busy | color_bit;
                REQ_DEF: begin
                  if (!dli_q) begin
                    busy <= busy | color_bit;
                  end
                end
                REQ_USE: busy <= busy & ~color_bit;
                default: begin
                  busy <= '0;
                  // new epoch retires every live mark; sweep on wrap
                  if (epoch == '1) begin
                    epoch   <= EPOCH_W'(1);
                    clr_cnt <= '0;
                  end else begin
                    epoch <= epoch + 1'b1;
                  end
                end
              endcase
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ica_free_scan.sv
// free colour search over one group of the busy mask per cycle
module ica_free_scan #(
  parameter int MAX_COLORS = ica_pkg::MAX_COLORS_DEF,
  localparam int NG = (MAX_COLORS + ica_pkg::GROUP_W - 1) / ica_pkg::GROUP_W,
  localparam int GW = (NG > 1) ? $clog2(NG) : 1
) (
  input  logic [MAX_COLORS-1:0]     busy,
  input  logic [ica_pkg::NUMC_W-1:0] num_colors,
  input  logic [GW-1:0]             grp,
  output ica_pkg::scan_res_t        res
);
  import ica_pkg::*;

  localparam int IB = $clog2(GROUP_W);

  logic [NG*GROUP_W-1:0] free_pad;
  logic [GROUP_W-1:0]    slice;
  logic [IB-1:0]         idx;

  always_comb begin
    free_pad = '0;
    for (int i = 0; i < MAX_COLORS; i++) begin
      free_pad[i] = ~busy[i] && (NUMC_W'(i) < num_colors);
    end
  end

  assign slice = free_pad[grp*GROUP_W +: GROUP_W];

  // lowest set bit wins
  always_comb begin
    idx = '0;
    for (int j = GROUP_W - 1; j >= 0; j--) begin
      if (slice[j]) begin
        idx = IB'(j);
      end
    end
  end

  assign res.hit   = |slice;
  assign res.color = COLOR_W'({grp, idx});

endmodule

FILE: rtl/ica_checker.sv
// port-level checks for the interval colour allocator, bound to the top level
module ica_port_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ica_pkg::COLOR_W-1:0]  color,
  input logic [ica_pkg::STATUS_W-1:0] status
);
  import ica_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color) && $stable(status))
    else $error("result beat changed while stalled");

  a_err_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (color == '0))
    else $error("error result carries a colour");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second event taken while one is in progress");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind interval_color_allocator ica_port_checks u_ica_checker (.*);
